[sv/mcs_pkg.sv]
// ----------------------------------------------------------------------------
// mcs_pkg
// Shared widths, types and helpers of the mask centroid steering unit.
// ----------------------------------------------------------------------------
package mcs_pkg;

  localparam int MAX_SIDE = 4096;
  localparam int POS_W    = $clog2(MAX_SIDE);
  localparam int SIDE_W   = 13;
  localparam int CNT_W    = 2 * POS_W + 1;
  localparam int SUM_W    = 3 * POS_W;
  localparam int GAIN_W   = 16;
  localparam int SPEED_W  = 28;
  localparam int ERR_W    = POS_W + 1;
  localparam int PROD_W   = ERR_W + GAIN_W + 1;
  localparam int CFG_W    = 16;
  localparam int IDX_W    = 2;
  localparam int OUT_W    = 112;

  typedef enum logic [IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_FORWARD_GAIN = 2'd2,
    REG_TURN_GAIN    = 2'd3
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_LOAD_COL,
    ST_WAIT_COL,
    ST_LOAD_ROW,
    ST_WAIT_ROW,
    ST_MUL_TURN,
    ST_MUL_FWD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] col_sum;
    logic [SUM_W-1:0] row_sum;
    logic [CNT_W-1:0] count;
  } frame_totals_t;

  localparam logic signed [SPEED_W-1:0] SPEED_MAX = {1'b0, {(SPEED_W-1){1'b1}}};
  localparam logic signed [SPEED_W-1:0] SPEED_MIN = {1'b1, {(SPEED_W-1){1'b0}}};

  function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
    logic [SIDE_W-1:0] r;
    r = v;
    if (v == '0) r = SIDE_W'(1);
    else if (v > SIDE_W'(MAX_SIDE)) r = SIDE_W'(MAX_SIDE);
    return r;
  endfunction

  function automatic logic [SPEED_W-1:0] sat_speed(input logic signed [PROD_W-1:0] p);
    logic [SPEED_W-1:0] r;
    r = p[SPEED_W-1:0];
    if (p > PROD_W'(SPEED_MAX)) r = SPEED_MAX;
    else if (p < $signed({{(PROD_W-SPEED_W){1'b1}}, SPEED_MIN})) r = SPEED_MIN;
    return r;
  endfunction

endpackage

[sv/mcs_accum.sv]
// ----------------------------------------------------------------------------
// mcs_accum
// Raster position tracking and per-frame sums of target pixel coordinates.
// ----------------------------------------------------------------------------
module mcs_accum (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        pix_take,
  input  logic [7:0]                  mask_value,
  input  logic [mcs_pkg::POS_W-1:0]   col_last,
  input  logic [mcs_pkg::POS_W-1:0]   row_last,
  output mcs_pkg::frame_totals_t      totals
);
  import mcs_pkg::*;

  logic [POS_W-1:0] col_pos;
  logic [POS_W-1:0] row_pos;
  logic [SUM_W-1:0] col_sum;
  logic [SUM_W-1:0] row_sum;
  logic [CNT_W-1:0] hit_count;
  logic [SUM_W-1:0] col_sum_next;
  logic [SUM_W-1:0] row_sum_next;
  logic [CNT_W-1:0] hit_count_next;
  logic             hit;
  logic             end_col;
  logic             end_row;

  assign hit            = (mask_value == 8'hFF);
  assign end_col        = (col_pos >= col_last);
  assign end_row        = (row_pos >= row_last);
  assign col_sum_next   = col_sum + (hit ? SUM_W'(col_pos) : '0);
  assign row_sum_next   = row_sum + (hit ? SUM_W'(row_pos) : '0);
  assign hit_count_next = hit_count + CNT_W'(hit);

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos     <= '0;
      row_pos     <= '0;
      col_sum     <= '0;
      row_sum     <= '0;
      hit_count   <= '0;
      totals.done <= 1'b0;
    end else begin
      totals.done <= 1'b0;
      if (pix_take) begin
        if (end_col && end_row) begin
          totals.done    <= 1'b1;
          totals.col_sum <= col_sum_next;
          totals.row_sum <= row_sum_next;
          totals.count   <= hit_count_next;
          col_pos        <= '0;
          row_pos        <= '0;
          col_sum        <= '0;
          row_sum        <= '0;
          hit_count      <= '0;
        end else begin
          col_sum   <= col_sum_next;
          row_sum   <= row_sum_next;
          hit_count <= hit_count_next;
          if (end_col) begin
            col_pos <= '0;
            row_pos <= row_pos + POS_W'(1);
          end else begin
            col_pos <= col_pos + POS_W'(1);
          end
        end
      end
    end
  end

endmodule

[sv/mcs_div.sv]
// ----------------------------------------------------------------------------
// mcs_div
// Shared restoring divider, one quotient bit per cycle; quotient fits POS_W.
// ----------------------------------------------------------------------------
module mcs_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [mcs_pkg::SUM_W-1:0]   dividend,
  input  logic [mcs_pkg::CNT_W-1:0]   divisor,
  output logic                        busy,
  output logic [mcs_pkg::POS_W-1:0]   quotient
);
  import mcs_pkg::*;

  localparam int STEP_W = $clog2(POS_W + 1);

  logic [CNT_W-1:0]  rem;
  logic [POS_W-1:0]  work;
  logic [STEP_W-1:0] steps;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              fits;

  assign trial    = {rem, work[POS_W-1]};
  assign fits     = (trial >= {1'b0, divisor});
  assign diff     = trial - {1'b0, divisor};
  assign quotient = work;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      steps <= STEP_W'(POS_W);
    end else if (busy) begin
      steps <= steps - STEP_W'(1);
      if (steps == STEP_W'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= {1'b0, dividend[SUM_W-1:POS_W]};
      work <= dividend[POS_W-1:0];
    end else if (busy) begin
      rem  <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      work <= {work[POS_W-2:0], fits};
    end
  end

endmodule

[sv/mask_centroid_steering_unit.sv]
// ----------------------------------------------------------------------------
// mask_centroid_steering_unit
// Centroid of a binary mask frame and proportional forward/turn steering.
// ----------------------------------------------------------------------------
// usage
//   s_* channel: one mask pixel per item in raster order; a pixel of 255 is
//   a target. while a frame streams in, one pixel is taken every cycle in
//   which s_tvalid is high. after the last pixel of a frame the block
//   drops s_tready and runs its sequencer: the shared divider finds the
//   mean column, then the mean row, one quotient bit per cycle, then the
//   shared multiplier forms the turn and forward speeds. a frame with no
//   target skips the arithmetic.
//   m_* channel: one result item per frame, held in an output register
//   until taken. a stalled receiver stalls the block only when a new result
//   is ready while the old one still waits.
//   cfg_*: register writes, to be issued only while no frame is in progress.
//   rst (synchronous) restores the default registers and starts a new frame
//   at column 0, row 0.
// ----------------------------------------------------------------------------
module mask_centroid_steering_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // mask_value
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // target_found, centroid_col, centroid_row, target_pixels,
  // forward_speed, turn_speed
  output logic [mcs_pkg::OUT_W-1:0]     m_tdata,
  input  logic                          cfg_we,
  input  logic [mcs_pkg::IDX_W-1:0]     cfg_index,
  input  logic [mcs_pkg::CFG_W-1:0]     cfg_data
);
  import mcs_pkg::*;

  state_t state;
  state_t state_next;

  logic [SIDE_W-1:0] frame_width;
  logic [SIDE_W-1:0] frame_height;
  logic [GAIN_W-1:0] forward_gain;
  logic [GAIN_W-1:0] turn_gain;
  logic [SIDE_W-1:0] w_side;
  logic [SIDE_W-1:0] h_side;
  logic [SIDE_W-1:0] w_last;
  logic [SIDE_W-1:0] h_last;

  frame_totals_t     totals;
  logic              pix_take;
  logic              found;

  logic              div_start;
  logic [SUM_W-1:0]  div_dividend;
  logic              div_busy;
  logic [POS_W-1:0]  div_quot;
  logic              cx_load;
  logic              cy_load;
  logic              mul_turn;
  logic              mul_fwd;
  logic              emit;
  logic              out_free;

  logic [POS_W-1:0]         cx;
  logic [POS_W-1:0]         cy;
  logic signed [ERR_W-1:0]  err_turn;
  logic signed [ERR_W-1:0]  err_fwd;
  logic signed [ERR_W-1:0]  mul_a;
  logic signed [GAIN_W:0]   mul_b;
  logic signed [PROD_W-1:0] prod;
  logic [SPEED_W-1:0]       turn_sat;

  logic                     o_found;
  logic [POS_W-1:0]         o_col;
  logic [POS_W-1:0]         o_row;
  logic [CNT_W-1:0]         o_pixels;
  logic [SPEED_W-1:0]       o_fwd;
  logic [SPEED_W-1:0]       o_turn;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= SIDE_W'(960);
      frame_height <= SIDE_W'(540);
      forward_gain <= GAIN_W'(131);
      turn_gain    <= GAIN_W'(197);
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[SIDE_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[SIDE_W-1:0];
        REG_FORWARD_GAIN: forward_gain <= cfg_data[GAIN_W-1:0];
        REG_TURN_GAIN:    turn_gain    <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign w_side = clamp_side(frame_width);
  assign h_side = clamp_side(frame_height);
  assign w_last = w_side - SIDE_W'(1);
  assign h_last = h_side - SIDE_W'(1);

  assign s_tready = (state == ST_ACCUM) && !totals.done;
  assign pix_take = s_tvalid && s_tready;
  assign found    = (totals.count != '0);
  assign out_free = !m_tvalid || m_tready;

  mcs_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .pix_take   (pix_take),
    .mask_value (s_tdata),
    .col_last   (w_last[POS_W-1:0]),
    .row_last   (h_last[POS_W-1:0]),
    .totals     (totals)
  );

  mcs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (totals.count),
    .busy     (div_busy),
    .quotient (div_quot)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= ST_ACCUM;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_ACCUM:    if (totals.done) state_next = found ? ST_LOAD_COL : ST_EMIT;
      ST_LOAD_COL: state_next = ST_WAIT_COL;
      ST_WAIT_COL: if (!div_busy) state_next = ST_LOAD_ROW;
      ST_LOAD_ROW: state_next = ST_WAIT_ROW;
      ST_WAIT_ROW: if (!div_busy) state_next = ST_MUL_TURN;
      ST_MUL_TURN: state_next = ST_MUL_FWD;
      ST_MUL_FWD:  state_next = ST_EMIT;
      ST_EMIT:     if (out_free) state_next = ST_ACCUM;
      default:     state_next = ST_ACCUM;
    endcase
  end

  always_comb begin
    div_start    = 1'b0;
    div_dividend = totals.col_sum;
    cx_load      = 1'b0;
    cy_load      = 1'b0;
    mul_turn     = 1'b0;
    mul_fwd      = 1'b0;
    emit         = 1'b0;
    unique case (state)
      ST_LOAD_COL: div_start = 1'b1;
      ST_WAIT_COL: cx_load = !div_busy;
      ST_LOAD_ROW: begin
        div_start    = 1'b1;
        div_dividend = totals.row_sum;
      end
      ST_WAIT_ROW: begin
        div_dividend = totals.row_sum;
        cy_load      = !div_busy;
      end
      ST_MUL_TURN: mul_turn = 1'b1;
      ST_MUL_FWD:  mul_fwd = 1'b1;
      ST_EMIT:     emit = out_free;
      default: ;
    endcase
  end

  // shared multiplier
  assign err_turn = $signed({1'b0, w_side[SIDE_W-1:1]}) - $signed({1'b0, cx});
  assign err_fwd  = $signed({1'b0, h_side[SIDE_W-1:1]}) - $signed({1'b0, cy});
  assign mul_a    = mul_fwd ? err_fwd : err_turn;
  assign mul_b    = $signed({1'b0, (mul_fwd ? forward_gain : turn_gain)});

  always_ff @(posedge clk) begin
    if (cx_load) cx <= div_quot;
    if (cy_load) cy <= div_quot;
    if (mul_turn || mul_fwd) prod <= PROD_W'(mul_a * mul_b);
    if (mul_fwd) turn_sat <= sat_speed(prod);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      o_found  <= found;
      o_col    <= found ? cx : '0;
      o_row    <= found ? cy : '0;
      o_pixels <= totals.count;
      o_fwd    <= found ? sat_speed(prod) : '0;
      o_turn   <= found ? turn_sat : '0;
    end
  end

  assign m_tdata = {{(OUT_W - 1 - 2 * POS_W - CNT_W - 2 * SPEED_W){1'b0}},
                    o_turn, o_fwd, o_pixels, o_row, o_col, o_found};

endmodule

[sim/tb_mask_centroid_steering_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mask_centroid_steering_unit
// Self-checking bench for the mask centroid steering unit. Mask frames are
// streamed in raster order under several frame sizes and gains, and a
// bit-true model of the centroid and steering math predicts one result per
// frame, which is checked field by field against the output stream.
// ----------------------------------------------------------------------------
module tb_mask_centroid_steering_unit;
  import mcs_pkg::*;

  localparam int  WATCHDOG_LIMIT = 4000;
  localparam int  SETTLE_CYCLES  = 40;
  localparam int  RANDOM_ITEMS   = 340;
  localparam longint SPEED_TOP    = 134217727;
  localparam longint SPEED_BOTTOM = -134217728;

  typedef struct packed {
    logic [27:0] turn;
    logic [27:0] fwd;
    logic [24:0] pixels;
    logic [11:0] row;
    logic [11:0] col;
    logic        found;
  } steer_result_t;

  typedef enum int {FILL_NONE, FILL_ALL, FILL_SPARSE, FILL_DENSE, FILL_NOISE} fill_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [7:0]         s_tdata = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [OUT_W-1:0]   m_tdata;
  logic               cfg_we = 1'b0;
  logic [IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]   cfg_data = '0;

  // frame registers and accumulators as the block should hold them
  logic [12:0]        width_reg = 13'd960;
  logic [12:0]        height_reg = 13'd540;
  logic [15:0]        fwd_gain_reg = 16'd131;
  logic [15:0]        turn_gain_reg = 16'd197;
  int unsigned        col_pos = 0;
  int unsigned        row_pos = 0;
  longint unsigned    col_acc = 0;
  longint unsigned    row_acc = 0;
  longint unsigned    hit_cnt = 0;

  steer_result_t      expected_q[$];
  int                 errors = 0;
  int                 items_sent = 0;
  int                 idle_cycles = 0;
  bit                 idle_on = 1'b1;

  mask_centroid_steering_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int unsigned fit_side(input logic [12:0] v);
    if (v == 13'd0) return 1;
    if (v > 13'd4096) return 4096;
    return 32'(v);
  endfunction

  function automatic logic [27:0] speed_q16(input longint err, input logic [15:0] gain);
    longint p;
    p = err * longint'(gain);
    if (p > SPEED_TOP) p = SPEED_TOP;
    if (p < SPEED_BOTTOM) p = SPEED_BOTTOM;
    return p[27:0];
  endfunction

  task automatic track_pixel(input logic [7:0] v);
    int unsigned     w;
    int unsigned     h;
    longint unsigned cx;
    longint unsigned cy;
    steer_result_t   r;
    w = fit_side(width_reg);
    h = fit_side(height_reg);
    if (v == 8'hFF) begin
      col_acc += col_pos;
      row_acc += row_pos;
      hit_cnt += 1;
    end
    if (col_pos < w - 1) begin
      col_pos++;
    end else if (row_pos < h - 1) begin
      col_pos = 0;
      row_pos++;
    end else begin
      r = '0;
      if (hit_cnt != 0) begin
        cx = col_acc / hit_cnt;
        cy = row_acc / hit_cnt;
        r.found  = 1'b1;
        r.col    = cx[11:0];
        r.row    = cy[11:0];
        r.pixels = hit_cnt[24:0];
        r.fwd    = speed_q16(longint'(h >> 1) - longint'(cy), fwd_gain_reg);
        r.turn   = speed_q16(longint'(w >> 1) - longint'(cx), turn_gain_reg);
      end
      expected_q.push_back(r);
      col_pos = 0;
      row_pos = 0;
      col_acc = 0;
      row_acc = 0;
      hit_cnt = 0;
    end
  endtask

  task automatic send_pixel(input logic [7:0] v);
    while (idle_on && $urandom_range(99) < 12) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    track_pixel(v);
  endtask

  function automatic logic [7:0] pick_pixel(input fill_t f);
    case (f)
      FILL_NONE:   return 8'($urandom_range(254));
      FILL_ALL:    return 8'hFF;
      FILL_SPARSE: return ($urandom_range(9) == 0) ? 8'hFF : 8'($urandom_range(254));
      FILL_DENSE:  return ($urandom_range(3) != 0) ? 8'hFF : 8'($urandom_range(255));
      default:     return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_frame(input fill_t f);
    int unsigned n;
    n = fit_side(width_reg) * fit_side(height_reg);
    for (int unsigned k = 0; k < n; k++) send_pixel(pick_pixel(f));
  endtask

  // background frame with a single target at raster position mark
  task automatic send_marked_frame(input int unsigned mark);
    int unsigned n;
    n = fit_side(width_reg) * fit_side(height_reg);
    for (int unsigned k = 0; k < n; k++)
      send_pixel((k == mark) ? 8'hFF : 8'($urandom_range(254)));
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // frame size only, gains keep their values
  task automatic set_frame_size(input logic [15:0] w, input logic [15:0] h);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    width_reg  = w[12:0];
    height_reg = h[12:0];
  endtask

  task automatic set_config(input logic [15:0] w, input logic [15:0] h,
                            input logic [15:0] fg, input logic [15:0] tg);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_index <= REG_FORWARD_GAIN;
    cfg_data  <= fg;
    @(posedge clk);
    cfg_index <= REG_TURN_GAIN;
    cfg_data  <= tg;
    @(posedge clk);
    cfg_we <= 1'b0;
    width_reg     = w[12:0];
    height_reg    = h[12:0];
    fwd_gain_reg  = fg;
    turn_gain_reg = tg;
  endtask

  task automatic test_reset_defaults();
    set_frame_size(16'd4, 16'd3);
    send_frame(FILL_DENSE);
    send_frame(FILL_ALL);
  endtask

  task automatic test_field_extremes();
    logic [7:0] no_hit[6];
    logic [7:0] some_hit[6];
    no_hit   = '{8'h00, 8'hFE, 8'h01, 8'h80, 8'h7F, 8'h55};
    some_hit = '{8'hFF, 8'h00, 8'hFF, 8'hAA, 8'hFF, 8'hFF};
    set_config(16'd3, 16'd2, 16'hFFFF, 16'h0000);
    foreach (no_hit[k]) send_pixel(no_hit[k]);
    foreach (some_hit[k]) send_pixel(some_hit[k]);
    // zero sizes act as one
    set_config(16'd0, 16'd0, 16'h0000, 16'hFFFF);
    send_pixel(8'hFF);
    send_pixel(8'h00);
    // bits above the width field are dropped
    set_config(16'hE005, 16'd2, 16'd40000, 16'd12345);
    send_frame(FILL_ALL);
  endtask

  task automatic test_size_extremes();
    set_config(16'd40, 16'd1, 16'hFFFF, 16'hFFFF);
    send_marked_frame(0);
    send_marked_frame(39);
    set_config(16'd1, 16'd40, 16'hFFFF, 16'hFFFF);
    send_marked_frame(39);
    send_marked_frame(0);
  endtask

  function automatic logic [15:0] pick_side(input int unsigned top);
    logic [15:0] v;
    case ($urandom_range(9))
      0:       v = 16'd0;
      1:       v = 16'd1;
      default: v = 16'($urandom_range(2, top));
    endcase
    if ($urandom_range(5) == 0) v[15:13] = 3'($urandom_range(7));
    return v;
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  task automatic test_random_frames();
    int start_items;
    int frame_no;
    start_items = items_sent;
    frame_no = 0;
    while (items_sent - start_items < RANDOM_ITEMS) begin
      if (frame_no == 0 || $urandom_range(2) == 0)
        set_config(pick_side(10), pick_side(6), pick_gain(), pick_gain());
      idle_on = !(frame_no >= 10 && frame_no < 18);
      send_frame(fill_t'($urandom_range(4)));
      frame_no++;
    end
    idle_on = 1'b1;
  endtask

  // result checking, receiver stalls and watchdog
  function automatic void check_field(input string name, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    steer_result_t want;
    steer_result_t got;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[105:0];
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected item, expected none, actual %h", $time, m_tdata);
        end else begin
          want = expected_q.pop_front();
          check_field("target_found", want.found, got.found);
          check_field("centroid_col", want.col, got.col);
          check_field("centroid_row", want.row, got.row);
          check_field("target_pixels", want.pixels, got.pixels);
          check_field("forward_speed", want.fwd, got.fwd);
          check_field("turn_speed", want.turn, got.turn);
          check_field("padding", 0, m_tdata[OUT_W-1:106]);
        end
      end
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("FAIL mask_centroid_steering_unit");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
    m_tready <= idle_on ? ($urandom_range(99) >= 12) : 1'b1;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_field_extremes();
    test_size_extremes();
    test_random_frames();
    settle();
    if (errors == 0) begin
      $display("PASS mask_centroid_steering_unit");
    end else begin
      $display("FAIL mask_centroid_steering_unit");
    end
    $finish;
  end

endmodule
